FILE: rtl/jof_pkg.sv
// shared types and character codes for the json object stream framer
`timescale 1ns / 1ps

package jof_pkg;

    // character codes
    localparam logic [7:0] CH_OPEN      = 8'h7B;
    localparam logic [7:0] CH_CLOSE     = 8'h7D;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_RETURN    = 8'h0D;

    localparam logic [31:0] LINE_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] LINE_ONE = 32'd1;

    // framing status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_ILLEGAL      = 2'd1,
        ST_UNTERMINATED = 2'd2
    } t_status;

    // one framed byte
    typedef struct packed {
        logic        in_object;
        logic        object_first;
        logic        object_last;
        t_status     status;
        logic [31:0] line_number;
        logic [31:0] object_start_line;
    } t_result;

endpackage

FILE: rtl/jof_in_if.sv
// request channel carrying one text byte
`timescale 1ns / 1ps

interface jof_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       stream_end;

    modport source (output valid, output text_byte, output stream_end, input ready);
    modport sink   (input valid, input text_byte, input stream_end, output ready);
endinterface

FILE: rtl/jof_out_if.sv
// request channel carrying one framing result
`timescale 1ns / 1ps

interface jof_out_if;
    logic        valid;
    logic        ready;
    logic        in_object;
    logic        object_first;
    logic        object_last;
    logic [1:0]  status;
    logic [31:0] line_number;
    logic [31:0] object_start_line;

    modport source (
        output valid, output in_object, output object_first, output object_last,
        output status, output line_number, output object_start_line, input ready
    );
    modport sink (
        input valid, input in_object, input object_first, input object_last,
        input status, input line_number, input object_start_line, output ready
    );
endinterface

FILE: rtl/jof_tracker.sv
// framing state and per-byte result logic
`timescale 1ns / 1ps

module jof_tracker
    import jof_pkg::*;
#(
    parameter int DEPTH_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_text_byte,
    input  logic       i_stream_end,
    output t_result    o_result
);

    logic                  r_inside, n_inside;
    logic                  r_in_string, n_in_string;
    logic                  r_escape, n_escape;
    logic [DEPTH_BITS-1:0] r_depth, n_depth;
    logic [31:0]           r_line, n_line;
    logic [31:0]           r_start, n_start;
    logic                  r_failed, n_failed;
    t_status               r_fail_code, n_fail_code;

    logic                  is_blank;
    logic                  is_newline;
    logic [31:0]           line_inc;
    t_result               res;

    assign is_blank   = (i_text_byte == CH_SPACE) ||
                        (i_text_byte inside {[CH_TAB:CH_RETURN]});
    assign is_newline = (i_text_byte == CH_NEWLINE);
    assign line_inc   = (r_line != LINE_MAX) ? r_line + LINE_ONE : r_line;

    // next state and result for the byte at the input
    always_comb begin
        n_inside    = r_inside;
        n_in_string = r_in_string;
        n_escape    = r_escape;
        n_depth     = r_depth;
        n_line      = r_line;
        n_start     = r_start;
        n_failed    = r_failed;
        n_fail_code = r_fail_code;

        res.in_object         = 1'b0;
        res.object_first      = 1'b0;
        res.object_last       = 1'b0;
        res.status            = ST_OK;
        res.line_number       = r_line;
        res.object_start_line = r_start;

        if (r_failed) begin
            res.status = r_fail_code;
        end else begin
            if (!r_inside) begin
                // between objects
                if (i_text_byte == CH_OPEN) begin
                    n_inside         = 1'b1;
                    n_in_string      = 1'b0;
                    n_escape         = 1'b0;
                    n_depth          = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
                    n_start          = r_line;
                    res.in_object    = 1'b1;
                    res.object_first = 1'b1;
                end else if (is_blank) begin
                    if (is_newline) begin
                        n_line = line_inc;
                    end
                end else begin
                    n_failed    = 1'b1;
                    n_fail_code = ST_ILLEGAL;
                    res.status  = ST_ILLEGAL;
                end
            end else begin
                // inside an object
                res.in_object = 1'b1;
                if (is_newline) begin
                    n_line = line_inc;
                end
                if (r_escape) begin
                    n_escape = 1'b0;
                end else if (i_text_byte == CH_QUOTE) begin
                    n_in_string = !r_in_string;
                end else if (i_text_byte == CH_BACKSLASH) begin
                    n_escape = 1'b1;
                end else if (i_text_byte == CH_OPEN) begin
                    if (!r_in_string && (r_depth != '1)) begin
                        n_depth = r_depth + 1'b1;
                    end
                end else if (i_text_byte == CH_CLOSE) begin
                    if (!r_in_string) begin
                        n_depth = (r_depth != '0) ? r_depth - 1'b1 : r_depth;
                        if (n_depth == '0) begin
                            n_inside        = 1'b0;
                            n_in_string     = 1'b0;
                            n_escape        = 1'b0;
                            res.object_last = 1'b1;
                        end
                    end
                end
            end

            // stream ends with an object still open
            if (!n_failed && i_stream_end && n_inside) begin
                n_failed    = 1'b1;
                n_fail_code = ST_UNTERMINATED;
                res.status  = ST_UNTERMINATED;
                n_inside    = 1'b0;
                n_in_string = 1'b0;
                n_escape    = 1'b0;
                n_depth     = '0;
            end
            res.object_start_line = n_start;
        end
    end

    assign o_result = res;

    // state registers, updated once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside    <= 1'b0;
            r_in_string <= 1'b0;
            r_escape    <= 1'b0;
            r_depth     <= '0;
            r_line      <= LINE_ONE;
            r_start     <= LINE_ONE;
            r_failed    <= 1'b0;
            r_fail_code <= ST_OK;
        end else if (i_fire) begin
            r_inside    <= n_inside;
            r_in_string <= n_in_string;
            r_escape    <= n_escape;
            r_depth     <= n_depth;
            r_line      <= n_line;
            r_start     <= n_start;
            r_failed    <= n_failed;
            r_fail_code <= n_fail_code;
        end
    end

    // an open object always has a nonzero depth
    a_depth_tracks_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inside == (r_depth != '0))
        else $error("depth and inside flag disagree");

    // errors are sticky
    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |=> r_failed)
        else $error("failed flag cleared without reset");

    // a failed framer holds no open object
    a_failed_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> (!r_inside && r_fail_code != ST_OK))
        else $error("failed framer still inside object");

endmodule

FILE: rtl/json_object_stream_framer.sv
// top level of the json object stream framer with output skid stage
`timescale 1ns / 1ps

// Frames a stream of whitespace-separated JSON objects, one byte per request.
// Every accepted byte yields exactly one result, tagged with object membership,
// first/last brace marks, a sticky error status and line numbers. A byte is
// accepted every clock unless the input stalls: the framing state is updated
// by a single pass of logic at the accept edge, which writes the result into
// the output register, or into the skid register while the output is stalled.
// A two-entry output stage (result register plus skid register) keeps the input
// ready for one more byte while a result waits to be taken; the input stalls
// only when both entries are full. Errors hold until reset.

module json_object_stream_framer
    import jof_pkg::*;
#(
    parameter int DEPTH_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jof_in_if.sink    i_in,
    jof_out_if.source o_out
);

    logic    in_fire;
    logic    out_take;
    t_result new_result;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    assign i_in.ready = !r_skid_valid;
    assign in_fire    = i_in.valid && !r_skid_valid;
    assign out_take   = !r_out_valid || o_out.ready;

    jof_tracker #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_text_byte  (i_in.text_byte),
        .i_stream_end (i_in.stream_end),
        .o_result     (new_result)
    );

    // output register and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out <= r_skid_valid ? r_skid : new_result;
        end
        if (!out_take && in_fire) begin
            r_skid <= new_result;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.in_object         = r_out.in_object;
    assign o_out.object_first      = r_out.object_first;
    assign o_out.object_last       = r_out.object_last;
    assign o_out.status            = r_out.status;
    assign o_out.line_number       = r_out.line_number;
    assign o_out.object_start_line = r_out.object_start_line;

    // skid entry is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds data while output register is empty");

    // a stalled output with a full skid keeps the input closed
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !o_out.ready) |=> r_skid_valid)
        else $error("skid entry lost while output stalled");

    // an opening brace is always part of an object
    a_first_in_object: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.object_first) |-> r_out.in_object)
        else $error("first mark outside object");

endmodule

FILE: test/tb.sv
// testbench for the json object stream framer: byte stream stimulus and framing checks
`timescale 1ns / 1ps

module tb;
    import jof_pkg::*;

    localparam int DEPTH_BITS = 16;
    localparam int RANDOM_ITEMS = 1350;
    localparam int DEEP_NEST = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jof_in_if  in_if ();
    jof_out_if out_if ();

    json_object_stream_framer #(
        .DEPTH_BITS(DEPTH_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // tracks the framing state and keeps the expected result of every accepted byte
    class frame_scoreboard;
        logic                  open_obj;
        logic                  quoted;
        logic                  escaped;
        logic [DEPTH_BITS-1:0] nest;
        logic [31:0]           line_now;
        logic [31:0]           obj_line;
        logic                  stuck;
        t_status               stuck_code;
        t_result               expected_frames[$];
        int                    mismatches;

        function new();
            open_obj   = 1'b0;
            quoted     = 1'b0;
            escaped    = 1'b0;
            nest       = '0;
            line_now   = LINE_ONE;
            obj_line   = LINE_ONE;
            stuck      = 1'b0;
            stuck_code = ST_OK;
            mismatches = 0;
        endfunction

        // advance the framing state by one accepted byte
        function void note_byte(logic [7:0] c, logic stream_last);
            t_result     r;
            logic [31:0] here;
            here = line_now;
            r = '0;
            r.status = ST_OK;
            if (stuck) begin
                r.status = stuck_code;
                r.line_number = line_now;
                r.object_start_line = obj_line;
                expected_frames.push_back(r);
                return;
            end
            if (!open_obj) begin
                if (c == CH_OPEN) begin
                    open_obj = 1'b1;
                    quoted   = 1'b0;
                    escaped  = 1'b0;
                    nest     = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
                    obj_line = here;
                    r.in_object    = 1'b1;
                    r.object_first = 1'b1;
                end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_RETURN)) begin
                    if (c == CH_NEWLINE && line_now != LINE_MAX) line_now++;
                end else begin
                    stuck      = 1'b1;
                    stuck_code = ST_ILLEGAL;
                    r.status   = ST_ILLEGAL;
                end
            end else begin
                r.in_object = 1'b1;
                // newlines count even when escaped or quoted
                if (c == CH_NEWLINE && line_now != LINE_MAX) line_now++;
                if (escaped) begin
                    escaped = 1'b0;
                end else if (c == CH_QUOTE) begin
                    quoted = !quoted;
                end else if (c == CH_BACKSLASH) begin
                    escaped = 1'b1;
                end else if (c == CH_OPEN) begin
                    if (!quoted && nest != {DEPTH_BITS{1'b1}}) nest++;
                end else if (c == CH_CLOSE) begin
                    if (!quoted) begin
                        if (nest != 0) nest--;
                        if (nest == 0) begin
                            open_obj = 1'b0;
                            quoted   = 1'b0;
                            escaped  = 1'b0;
                            r.object_last = 1'b1;
                        end
                    end
                end
            end
            // stream ends with an object still open
            if (!stuck && stream_last && open_obj) begin
                stuck      = 1'b1;
                stuck_code = ST_UNTERMINATED;
                r.status   = ST_UNTERMINATED;
                open_obj   = 1'b0;
                quoted     = 1'b0;
                escaped    = 1'b0;
                nest       = '0;
            end
            r.line_number = here;
            r.object_start_line = obj_line;
            expected_frames.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
            mismatches++;
        endtask

        // compare one accepted result with the oldest expectation
        task check_result(logic io, logic f, logic l, logic [1:0] st,
                          logic [31:0] ln, logic [31:0] sl);
            t_result want;
            if (expected_frames.size() == 0) begin
                report("unexpected result", {30'd0, st}, 32'd0);
                return;
            end
            want = expected_frames.pop_front();
            if (io !== want.in_object)
                report("in_object", 32'(io), 32'(want.in_object));
            if (f !== want.object_first)
                report("object_first", 32'(f), 32'(want.object_first));
            if (l !== want.object_last)
                report("object_last", 32'(l), 32'(want.object_last));
            if (st !== want.status)
                report("status", 32'(st), 32'(want.status));
            if (ln !== want.line_number)      report("line_number", ln, want.line_number);
            if (sl !== want.object_start_line)
                report("object_start_line", sl, want.object_start_line);
        endtask
    endclass

    frame_scoreboard sb = new();

    logic idle_on = 1'b0;
    int   hold_req = 0;
    int   sent = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // drive one byte and wait for it to be accepted
    task send_byte(logic [7:0] b, logic e);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.text_byte  <= b;
        in_if.stream_end <= e;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_byte(b, e);
        sent++;
    endtask

    // one well-formed object with random content, then a few blanks
    task send_object();
        int         target;
        int         n;
        int         pick;
        int         blanks;
        logic [7:0] b;
        logic       closes;
        target = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
        n = 0;
        send_byte(CH_OPEN, 1'b0);
        while (sb.open_obj) begin
            if (n < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 25)      b = 8'($urandom_range(0, 255));
                else if (pick < 35) b = CH_QUOTE;
                else if (pick < 43) b = CH_BACKSLASH;
                else if (pick < 53) b = CH_OPEN;
                else if (pick < 63) b = CH_CLOSE;
                else if (pick < 70) b = CH_NEWLINE;
                else                b = 8'($urandom_range(8'h61, 8'h7A));
            end else if (sb.escaped) begin
                b = 8'($urandom_range(0, 255));
            end else if (sb.quoted) begin
                b = CH_QUOTE;
            end else begin
                b = CH_CLOSE;
            end
            // stream end only on the brace that closes the object
            closes = (b == CH_CLOSE) && !sb.escaped && !sb.quoted && (sb.nest == 1);
            send_byte(b, closes && ($urandom_range(0, 5) == 0));
            n++;
        end
        blanks = $urandom_range(0, 3);
        repeat (blanks) begin
            case ($urandom_range(0, 5))
                0: b = CH_SPACE;
                1: b = CH_TAB;
                2: b = CH_NEWLINE;
                3: b = 8'h0B;
                4: b = 8'h0C;
                default: b = CH_RETURN;
            endcase
            send_byte(b, $urandom_range(0, 9) == 0);
        end
    endtask

    // result side: check accepted results and stall at random
    initial begin
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.in_object, out_if.object_first, out_if.object_last,
                                out_if.status, out_if.line_number, out_if.object_start_line);
            if (!i_rst_n) begin
                out_if.ready <= 1'b0;
            end else begin
                if (hold_req > 0) begin
                    stall_left = hold_req;
                    hold_req = 0;
                end
                if (stall_left > 0) begin
                    stall_left--;
                    out_if.ready <= 1'b0;
                end else if (idle_on && $urandom_range(0, 5) == 0) begin
                    stall_left = $urandom_range(0, 10);
                    out_if.ready <= 1'b0;
                end else begin
                    out_if.ready <= 1'b1;
                end
            end
        end
    end

    // run limit
    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // main stimulus
    initial begin
        logic       pressed;
        logic [7:0] b;
        pressed = 1'b0;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.text_byte  <= 8'h00;
        in_if.stream_end <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // whitespace set between objects
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(8'h0B, 1'b0);
        send_byte(8'h0C, 1'b0);
        send_byte(CH_RETURN, 1'b0);
        // string with a brace, an escaped quote and a quoted close brace
        send_byte(CH_OPEN, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_OPEN, 1'b0);
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_CLOSE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        // newline inside, escaped newline, escaped brace outside a string
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_CLOSE, 1'b0);
        // byte extremes and a nested object
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_OPEN, 1'b0);
        send_byte(CH_CLOSE, 1'b0);
        // closing brace together with stream end
        send_byte(CH_CLOSE, 1'b1);
        // clean stream end, then the stream continues
        send_byte(CH_SPACE, 1'b1);
        send_byte(CH_OPEN, 1'b0);
        send_byte(CH_CLOSE, 1'b0);

        // random well-formed objects with idling
        idle_on = 1'b1;
        while (sent < RANDOM_ITEMS - 90) begin
            if ($urandom_range(0, 9) == 0) idle_on = !idle_on;
            if (!pressed && sent > 700) begin
                // long receiver hold so the output stage fills and the input stalls
                hold_req = 400;
                pressed = 1'b1;
            end
            send_object();
        end

        // last part without idling: deep nesting
        idle_on = 1'b0;
        send_byte(CH_OPEN, 1'b0);
        repeat (DEEP_NEST) send_byte(CH_OPEN, 1'b0);
        repeat (DEEP_NEST) send_byte(CH_CLOSE, 1'b0);
        send_byte(CH_CLOSE, 1'b0);

        // one sticky error, then bytes that are ignored
        if ($urandom_range(0, 1) == 0) begin
            do b = 8'($urandom_range(0, 255));
            while (b == CH_OPEN || b == CH_SPACE || (b >= CH_TAB && b <= CH_RETURN));
            send_byte(b, 1'b0);
        end else begin
            send_byte(CH_OPEN, 1'b0);
            send_byte(CH_QUOTE, 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        repeat (20) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        in_if.valid <= 1'b0;

        while (sb.expected_frames.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_frames.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
